[sv/bct_pkg.sv]
package bct_pkg;

	// Timer states, one-hot
	typedef enum logic [4:0] {
		ST_RESET    = 5'b00001,
		ST_STARTED  = 5'b00010,
		ST_STOPPED  = 5'b00100,
		ST_TIMESET  = 5'b01000,
		ST_FINISHED = 5'b10000
	} run_mode_t;

	// run_state codes on the result channel
	localparam logic [2:0] RS_RESET    = 3'd0;
	localparam logic [2:0] RS_STARTED  = 3'd1;
	localparam logic [2:0] RS_STOPPED  = 3'd2;
	localparam logic [2:0] RS_TIMESET  = 3'd3;
	localparam logic [2:0] RS_FINISHED = 3'd4;

	// Button codes
	localparam logic [2:0] BTN_NONE   = 3'd0;
	localparam logic [2:0] BTN_A      = 3'd1;
	localparam logic [2:0] BTN_A_LONG = 3'd2;
	localparam logic [2:0] BTN_B      = 3'd3;
	localparam logic [2:0] BTN_B_LONG = 3'd4;
	localparam logic [2:0] BTN_C_LONG = 3'd5;

	// Configuration register indexes
	localparam logic CFG_MAX_SECONDS = 1'b0;
	localparam logic CFG_MAX_MINUTES = 1'b1;

	localparam logic [7:0] MAX_SECONDS_RST = 8'd59;
	localparam logic [7:0] MAX_MINUTES_RST = 8'd99;

	// Remaining-time counter: whole minutes, seconds, milliseconds
	localparam logic [9:0] MS_TOP  = 10'd999;
	localparam logic [5:0] SEC_TOP = 6'd59;

	typedef struct packed {
		logic [8:0] mins;
		logic [5:0] secs;
		logic [9:0] ms;
	} rem_t;

	typedef struct packed {
		logic restart;
		logic dec;
	} rem_ctl_t;

	function automatic logic [7:0] edit_value(input logic [7:0] v, input logic [7:0] maxv,
		input logic [2:0] btn);
		logic [8:0] up10;
		logic [7:0] res;
		up10 = {1'b0, v} + 9'd10;
		case (btn)
			BTN_A:      res = (v < maxv) ? v + 8'd1 : 8'd0;
			BTN_A_LONG: res = (up10 < {1'b0, maxv}) ? up10[7:0] : 8'd0;
			BTN_B:      res = (v != 8'd0) ? v - 8'd1 : maxv;
			BTN_B_LONG: res = (v > 8'd10) ? v - 8'd10 : maxv;
			default:    res = v;
		endcase
		return res;
	endfunction

	function automatic logic [2:0] state_code(input run_mode_t m);
		logic [2:0] c;
		unique case (m)
			ST_RESET:    c = RS_RESET;
			ST_STARTED:  c = RS_STARTED;
			ST_STOPPED:  c = RS_STOPPED;
			ST_TIMESET:  c = RS_TIMESET;
			ST_FINISHED: c = RS_FINISHED;
			default:     c = RS_RESET;
		endcase
		return c;
	endfunction

endpackage

[sv/bct_ifs.sv]
interface bct_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [2:0] button;
	logic       tick;
	logic [7:0] load_minutes;
	logic [7:0] load_seconds;

	modport source (output valid, mode, button, tick, load_minutes, load_seconds,
		input ready);
	modport sink (input valid, mode, button, tick, load_minutes, load_seconds,
		output ready);
endinterface

interface bct_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] minutes_shown;
	logic [7:0] seconds_shown;
	logic [2:0] run_state;
	logic       editing_minutes;
	logic       saved;

	modport source (output valid, minutes_shown, seconds_shown, run_state, editing_minutes,
		saved, input ready);
	modport sink (input valid, minutes_shown, seconds_shown, run_state, editing_minutes,
		saved, output ready);
endinterface

[sv/button_countdown_timer.sv]
// Channel  Dir  Handshake     Payload
// item     in   valid/ready   mode, button, tick, load_minutes, load_seconds
// result   out  valid/ready   minutes_shown, seconds_shown, run_state,
//                             editing_minutes, saved
// cfg      in   cfg_we        cfg_index (0 seconds limit, 1 minutes limit), cfg_data
//
// One request per cycle while item.ready is high. A request is evaluated against
// the timer state in the cycle it is accepted; its result is registered and shows
// up in the next cycle. The single result register is the only buffering: item.ready
// stays high while the result register is empty or being drained this cycle.
// arst_n clears state to reset mode, seconds editing, zero preset/display, and
// the limits to 59 s / 99 min.
module button_countdown_timer (
	input  logic       clk,
	input  logic       arst_n,
	bct_in_if.sink     item,
	bct_out_if.source  result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// Config limits
	logic [7:0] max_sec_q, max_min_q;

	// Timer state
	bct_pkg::run_mode_t mode_q;
	logic       edit_min_q;
	logic [7:0] preset_min_q, preset_sec_q;
	logic [7:0] shown_min_q, shown_sec_q;

	// Result register
	logic       res_valid_q;
	logic [7:0] res_min_q, res_sec_q;
	logic [2:0] res_state_q;
	logic       res_edit_q, res_saved_q;

	logic accept;
	logic btn_ok;

	// After button handling
	bct_pkg::run_mode_t mode_btn;
	logic       edit_nxt;
	logic [7:0] preset_min_nxt, preset_sec_nxt;
	logic [7:0] shown_min_btn, shown_sec_btn;
	logic       saved_nxt;
	logic       restart, to_timeset;

	// After the time update
	bct_pkg::run_mode_t mode_nxt;
	logic [7:0] shown_min_nxt, shown_sec_nxt;

	bct_pkg::rem_ctl_t rem_ctl;
	bct_pkg::rem_t     rem_nxt;

	// Output side frees up when empty or drained in this cycle
	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign btn_ok = (item.button != bct_pkg::BTN_NONE) &&
		(item.button <= bct_pkg::BTN_C_LONG);

	// Button handling, or preset load in load mode
	always_comb begin
		mode_btn       = mode_q;
		edit_nxt       = edit_min_q;
		preset_min_nxt = preset_min_q;
		preset_sec_nxt = preset_sec_q;
		shown_min_btn  = shown_min_q;
		shown_sec_btn  = shown_sec_q;
		saved_nxt      = 1'b0;
		restart        = 1'b0;
		to_timeset     = 1'b0;

		if (item.mode) begin
			preset_min_nxt = item.load_minutes;
			preset_sec_nxt = item.load_seconds;
			restart        = 1'b1;
		end else if (btn_ok) begin
			unique case (mode_q)
				bct_pkg::ST_RESET: begin
					if (item.button == bct_pkg::BTN_A) begin
						mode_btn = bct_pkg::ST_STARTED;
					end else if (item.button == bct_pkg::BTN_C_LONG) begin
						mode_btn = bct_pkg::ST_TIMESET;
					end
				end
				bct_pkg::ST_STARTED: begin
					if (item.button == bct_pkg::BTN_A) begin
						mode_btn = bct_pkg::ST_STOPPED;
					end
				end
				bct_pkg::ST_STOPPED: begin
					if (item.button == bct_pkg::BTN_A) begin
						mode_btn = bct_pkg::ST_STARTED;
					end else if (item.button == bct_pkg::BTN_B) begin
						restart = 1'b1;
					end else if (item.button == bct_pkg::BTN_C_LONG) begin
						restart    = 1'b1;
						to_timeset = 1'b1;
					end
				end
				bct_pkg::ST_TIMESET: begin
					if (item.button == bct_pkg::BTN_C_LONG) begin
						if (!edit_min_q) begin
							edit_nxt = 1'b1;
						end else begin
							// save edited time as the new preset
							preset_min_nxt = shown_min_q;
							preset_sec_nxt = shown_sec_q;
							restart        = 1'b1;
							saved_nxt      = 1'b1;
						end
					end else if (!edit_min_q) begin
						shown_sec_btn = bct_pkg::edit_value(shown_sec_q, max_sec_q,
							item.button);
					end else begin
						shown_min_btn = bct_pkg::edit_value(shown_min_q, max_min_q,
							item.button);
					end
				end
				bct_pkg::ST_FINISHED: begin
					restart = 1'b1;
				end
				default: ;
			endcase
		end

		// Restart: display back to preset, seconds field, reset mode (time set mode on to_timeset)
		if (restart) begin
			shown_min_btn = preset_min_nxt;
			shown_sec_btn = preset_sec_nxt;
			edit_nxt      = 1'b0;
			mode_btn      = to_timeset ? bct_pkg::ST_TIMESET : bct_pkg::ST_RESET;
		end
	end

	// Counter moves only on an accepted request: restart, or a tick while running
	always_comb begin
		rem_ctl.restart = accept && restart;
		rem_ctl.dec     = accept && !item.mode && item.tick &&
			(mode_btn == bct_pkg::ST_STARTED);
	end

	bct_remain u_remain (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (rem_ctl),
		.preset_minutes (preset_min_nxt),
		.preset_seconds (preset_sec_nxt),
		.nxt            (rem_nxt)
	);

	// While running: finish when nothing remains, else show whole seconds left.
	// Display saturates at 255:59 when minutes exceed 8 bits.
	always_comb begin
		mode_nxt      = mode_btn;
		shown_min_nxt = shown_min_btn;
		shown_sec_nxt = shown_sec_btn;
		if (mode_btn == bct_pkg::ST_STARTED) begin
			if (rem_nxt == '0) begin
				mode_nxt = bct_pkg::ST_FINISHED;
			end else if (rem_nxt.mins[8]) begin
				shown_min_nxt = 8'd255;
				shown_sec_nxt = {2'b00, bct_pkg::SEC_TOP};
			end else begin
				shown_min_nxt = rem_nxt.mins[7:0];
				shown_sec_nxt = {2'b00, rem_nxt.secs};
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sec_q <= bct_pkg::MAX_SECONDS_RST;
			max_min_q <= bct_pkg::MAX_MINUTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bct_pkg::CFG_MAX_SECONDS: max_sec_q <= cfg_data;
				bct_pkg::CFG_MAX_MINUTES: max_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Timer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= bct_pkg::ST_RESET;
			edit_min_q   <= 1'b0;
			preset_min_q <= '0;
			preset_sec_q <= '0;
			shown_min_q  <= '0;
			shown_sec_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				mode_q       <= mode_nxt;
				edit_min_q   <= edit_nxt;
				preset_min_q <= preset_min_nxt;
				preset_sec_q <= preset_sec_nxt;
				shown_min_q  <= shown_min_nxt;
				shown_sec_q  <= shown_sec_nxt;
				res_valid_q  <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_min_q   <= shown_min_nxt;
			res_sec_q   <= shown_sec_nxt;
			res_state_q <= bct_pkg::state_code(mode_nxt);
			res_edit_q  <= edit_nxt;
			res_saved_q <= saved_nxt;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.minutes_shown   = res_min_q;
	assign result.seconds_shown   = res_sec_q;
	assign result.run_state       = res_state_q;
	assign result.editing_minutes = res_edit_q;
	assign result.saved           = res_saved_q;

endmodule

[sv/bct_remain.sv]
// Remaining time as a min/sec/ms down-counter; equals duration minus elapsed.
module bct_remain (
	input  logic             clk,
	input  logic             arst_n,
	input  bct_pkg::rem_ctl_t ctl,
	input  logic [7:0]       preset_minutes,
	input  logic [7:0]       preset_seconds,
	output bct_pkg::rem_t    nxt
);

	bct_pkg::rem_t rem_q;
	logic [2:0] carry;
	logic [7:0] sec_rem;

	// Split preset seconds (up to 255) into carry minutes and seconds
	always_comb begin
		if (preset_seconds >= 8'd240) begin
			carry = 3'd4;
			sec_rem = preset_seconds - 8'd240;
		end else if (preset_seconds >= 8'd180) begin
			carry = 3'd3;
			sec_rem = preset_seconds - 8'd180;
		end else if (preset_seconds >= 8'd120) begin
			carry = 3'd2;
			sec_rem = preset_seconds - 8'd120;
		end else if (preset_seconds >= 8'd60) begin
			carry = 3'd1;
			sec_rem = preset_seconds - 8'd60;
		end else begin
			carry = 3'd0;
			sec_rem = preset_seconds;
		end
	end

	always_comb begin
		nxt = rem_q;
		if (ctl.restart) begin
			nxt.mins = {1'b0, preset_minutes} + {6'd0, carry};
			nxt.secs = sec_rem[5:0];
			nxt.ms   = '0;
		end else if (ctl.dec) begin
			if (rem_q.ms != '0) begin
				nxt.ms = rem_q.ms - 10'd1;
			end else if (rem_q.secs != '0) begin
				nxt.secs = rem_q.secs - 6'd1;
				nxt.ms   = bct_pkg::MS_TOP;
			end else if (rem_q.mins != '0) begin
				nxt.mins = rem_q.mins - 9'd1;
				nxt.secs = bct_pkg::SEC_TOP;
				nxt.ms   = bct_pkg::MS_TOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else begin
			rem_q <= nxt;
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import bct_pkg::*;

	// One request into the timer and the display it is expected to produce
	typedef struct packed {
		logic       mode;
		logic [2:0] button;
		logic       tick;
		logic [7:0] load_minutes;
		logic [7:0] load_seconds;
	} timer_req_t;

	typedef struct packed {
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic [2:0] state;
		logic       editing;
		logic       saved;
	} timer_disp_t;

	// Button codes six and seven have no meaning; the timer must treat them as no press
	localparam logic [2:0] BTN_UNUSED6 = 3'd6;
	localparam logic [2:0] BTN_UNUSED7 = 3'd7;

	localparam int IDLE_LIMIT       = 2000;  // cycles with no handshake at all
	localparam int HOLD_OFF_CYCLES  = 300;   // long receiver stall for the pressure test
	localparam int RANDOM_PER_PHASE = 4;     // short random stretch per limit setting

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	bct_in_if  req_ch();
	bct_out_if disp_ch();

	button_countdown_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (req_ch),
		.result   (disp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the timer: limits, run mode, edit field, preset,
	// display and elapsed milliseconds
	// ---------------------------------------------------------------
	logic [7:0]  lim_seconds, lim_minutes;
	run_mode_t   tmr_mode;
	logic        tmr_edit_min;
	logic [7:0]  tmr_preset_min, tmr_preset_sec;
	logic [7:0]  tmr_show_min, tmr_show_sec;
	logic [23:0] tmr_elapsed;

	timer_disp_t expected_displays[$];

	int mismatch_count = 0;
	int requests_sent  = 0;
	int burst_left     = 0;
	int hold_off_req   = 0;
	int idle_cycles    = 0;

	function automatic void reset_timer_shadow();
		lim_seconds    = MAX_SECONDS_RST;
		lim_minutes    = MAX_MINUTES_RST;
		tmr_mode       = ST_RESET;
		tmr_edit_min   = 1'b0;
		tmr_preset_min = 8'd0;
		tmr_preset_sec = 8'd0;
		tmr_show_min   = 8'd0;
		tmr_show_sec   = 8'd0;
		tmr_elapsed    = 24'd0;
	endfunction

	// Back to reset mode with the preset on the display, seconds selected
	function automatic void restart_timer();
		tmr_elapsed  = 24'd0;
		tmr_show_min = tmr_preset_min;
		tmr_show_sec = tmr_preset_sec;
		tmr_mode     = ST_RESET;
		tmr_edit_min = 1'b0;
	endfunction

	// Edit step with wrap; a value above the limit wraps the same way
	function automatic logic [7:0] stepped_value(input logic [7:0] v, input logic [7:0] lim,
		input logic [2:0] btn);
		logic [8:0] plus_ten;
		plus_ten = {1'b0, v} + 9'd10;
		case (btn)
			BTN_A:      return (v < lim) ? v + 8'd1 : 8'd0;
			BTN_A_LONG: return (plus_ten < {1'b0, lim}) ? plus_ten[7:0] : 8'd0;
			BTN_B:      return (v != 8'd0) ? v - 8'd1 : lim;
			BTN_B_LONG: return (v > 8'd10) ? v - 8'd10 : lim;
			default:    return v;
		endcase
	endfunction

	// Button handling per run mode; returns 1 when the preset was saved
	function automatic logic apply_button(input logic [2:0] btn);
		logic stored;
		stored = 1'b0;
		if (btn == BTN_NONE || btn > BTN_C_LONG)
			return 1'b0;
		case (tmr_mode)
			ST_RESET: begin
				if (btn == BTN_A)
					tmr_mode = ST_STARTED;
				else if (btn == BTN_C_LONG)
					tmr_mode = ST_TIMESET;
			end
			ST_STARTED: begin
				if (btn == BTN_A)
					tmr_mode = ST_STOPPED;
			end
			ST_STOPPED: begin
				if (btn == BTN_A) begin
					tmr_mode = ST_STARTED;
				end else if (btn == BTN_B) begin
					restart_timer();
				end else if (btn == BTN_C_LONG) begin
					restart_timer();
					tmr_mode = ST_TIMESET;
				end
			end
			ST_TIMESET: begin
				if (btn == BTN_C_LONG) begin
					if (!tmr_edit_min) begin
						tmr_edit_min = 1'b1;
					end else begin
						tmr_preset_min = tmr_show_min;
						tmr_preset_sec = tmr_show_sec;
						restart_timer();
						stored = 1'b1;
					end
				end else if (!tmr_edit_min) begin
					tmr_show_sec = stepped_value(tmr_show_sec, lim_seconds, btn);
				end else begin
					tmr_show_min = stepped_value(tmr_show_min, lim_minutes, btn);
				end
			end
			ST_FINISHED: restart_timer();
			default: ;
		endcase
		return stored;
	endfunction

	// Tick, finish test and remaining-time display while started
	function automatic void count_down(input logic tick);
		int unsigned duration, remaining, whole_min;
		if (tick && tmr_elapsed != 24'hFFFFFF)
			tmr_elapsed = tmr_elapsed + 24'd1;
		duration = {24'd0, tmr_preset_min} * 32'd60000 + {24'd0, tmr_preset_sec} * 32'd1000;
		if ({8'd0, tmr_elapsed} >= duration) begin
			tmr_mode = ST_FINISHED;
			return;
		end
		remaining = (duration - {8'd0, tmr_elapsed}) / 32'd1000;
		whole_min = remaining / 32'd60;
		if (whole_min > 32'd255) begin
			// more than the display can hold: pin to 255:59
			tmr_show_min = 8'd255;
			tmr_show_sec = 8'd59;
		end else begin
			tmr_show_min = whole_min[7:0];
			tmr_show_sec = 8'(remaining % 32'd60);
		end
	endfunction

	function automatic logic [2:0] run_state_code(input run_mode_t m);
		case (m)
			ST_STARTED:  return RS_STARTED;
			ST_STOPPED:  return RS_STOPPED;
			ST_TIMESET:  return RS_TIMESET;
			ST_FINISHED: return RS_FINISHED;
			default:     return RS_RESET;
		endcase
	endfunction

	function automatic timer_disp_t predict_display(input timer_req_t r);
		timer_disp_t d;
		logic stored;
		stored = 1'b0;
		if (r.mode) begin
			// load mode: preset from the store, then restart; button and tick ignored
			tmr_preset_min = r.load_minutes;
			tmr_preset_sec = r.load_seconds;
			restart_timer();
		end else begin
			// button first, then the tick if the timer ends up started
			stored = apply_button(r.button);
			if (tmr_mode == ST_STARTED)
				count_down(r.tick);
		end
		d.minutes = tmr_show_min;
		d.seconds = tmr_show_sec;
		d.state   = run_state_code(tmr_mode);
		d.editing = tmr_edit_min;
		d.saved   = stored;
		return d;
	endfunction

	// ---------------------------------------------------------------
	// Monitors: predict on every accepted request, check every result
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_displays.push_back(predict_display(timer_req_t'{req_ch.mode,
				req_ch.button, req_ch.tick, req_ch.load_minutes, req_ch.load_seconds}));
	end

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		timer_disp_t want;
		if (arst_n && disp_ch.valid && disp_ch.ready) begin
			if (expected_displays.size() == 0) begin
				$display("%0t: result with no request pending, expected none, %s",
					$time, "actual");
				$display("    %0d:%0d state %0d", disp_ch.minutes_shown,
					disp_ch.seconds_shown, disp_ch.run_state);
				mismatch_count++;
			end else begin
				want = expected_displays.pop_front();
				compare_field("minutes_shown", want.minutes, disp_ch.minutes_shown);
				compare_field("seconds_shown", want.seconds, disp_ch.seconds_shown);
				compare_field("run_state", {5'd0, want.state}, {5'd0, disp_ch.run_state});
				compare_field("editing_minutes", {7'd0, want.editing},
					{7'd0, disp_ch.editing_minutes});
				compare_field("saved", {7'd0, want.saved}, {7'd0, disp_ch.saved});
			end
		end
	end

	// Watchdog: too long without any handshake means the block hung
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (disp_ch.valid && disp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: stall pattern changes every segment; a long hold-off request
	// from a test overrides the pattern and is counted down here
	initial begin
		int seg_left;
		int seg_kind;
		int period;
		int phase;
		seg_left = 0;
		seg_kind = 0;
		period   = 2;
		phase    = 0;
		disp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req > 0) begin
				disp_ch.ready <= 1'b0;
				hold_off_req--;
			end else begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 80);
					period   = $urandom_range(2, 5);
				end
				seg_left--;
				phase++;
				case (seg_kind)
					0:       disp_ch.ready <= 1'b1;
					1:       disp_ch.ready <= 1'($urandom_range(0, 1));
					2:       disp_ch.ready <= (phase % period) != 0;
					default: disp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	function automatic timer_req_t make_request(input logic mode, input logic [2:0] button,
		input logic tick, input logic [7:0] load_minutes, input logic [7:0] load_seconds);
		return timer_req_t'{mode, button, tick, load_minutes, load_seconds};
	endfunction

	// Sends one request in bursts with random gaps; returns at the accepting edge.
	// Callers follow with another send or with drain_requests.
	task automatic send_request(input timer_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= r.mode;
		req_ch.button       <= r.button;
		req_ch.tick         <= r.tick;
		req_ch.load_minutes <= r.load_minutes;
		req_ch.load_seconds <= r.load_seconds;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Normal step; the load fields carry junk that must be ignored
	task automatic press(input logic [2:0] btn, input logic tick);
		send_request(make_request(1'b0, btn, tick, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))));
	endtask

	// Load mode with junk button and tick
	task automatic load_preset(input logic [7:0] mins, input logic [7:0] secs);
		send_request(make_request(1'b1, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			mins, secs));
	endtask

	// Stop offering and wait until every result is back (one result per request,
	// registered), then let the block settle
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_displays.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Only called while the block is idle
	task automatic write_limit(input logic idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == CFG_MAX_SECONDS)
			lim_seconds = value;
		else
			lim_minutes = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [2:0] edit_button();
		case ($urandom_range(0, 11))
			0, 1:    return BTN_A;
			2, 3:    return BTN_A_LONG;
			4, 5:    return BTN_B;
			6, 7:    return BTN_B_LONG;
			8:       return BTN_NONE;
			9:       return BTN_UNUSED6;
			10:      return BTN_UNUSED7;
			default: return BTN_C_LONG;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------
	task automatic test_idle_after_reset();
		press(BTN_NONE, 1'b1);     // tick in reset mode does nothing
		press(BTN_UNUSED6, 1'b0);
		drain_requests();
	endtask

	task automatic test_state_flow();
		press(BTN_A, 1'b0);        // zero preset: starts and finishes at once
		press(BTN_UNUSED7, 1'b1);  // no press: stays finished
		press(BTN_B, 1'b0);        // any button restarts from finished
		load_preset(8'd1, 8'd30);
		press(BTN_C_LONG, 1'b0);   // reset -> time set, seconds
		press(BTN_A, 1'b0);
		press(BTN_A_LONG, 1'b0);
		press(BTN_B, 1'b1);
		press(BTN_B_LONG, 1'b0);
		press(BTN_UNUSED6, 1'b0);
		press(BTN_C_LONG, 1'b0);   // -> minutes
		press(BTN_A_LONG, 1'b0);
		press(BTN_B, 1'b0);
		press(BTN_C_LONG, 1'b0);   // save and restart
		press(BTN_A, 1'b1);        // start, tick in the same step
		press(BTN_NONE, 1'b1);
		press(BTN_A, 1'b0);        // stop
		press(BTN_B_LONG, 1'b1);   // ignored while stopped
		press(BTN_A, 1'b1);        // start again
		press(BTN_C_LONG, 1'b0);   // ignored while started
		press(BTN_A, 1'b0);
		press(BTN_C_LONG, 1'b0);   // stopped: restart, then time set
		// load while editing: back to reset, seconds selected, button and tick ignored
		send_request(make_request(1'b1, BTN_A, 1'b1, 8'd0, 8'd2));
		press(BTN_A, 1'b0);
		press(BTN_A, 1'b0);
		press(BTN_B, 1'b0);        // stopped: restart
		drain_requests();
	endtask

	task automatic test_edit_limits();
		write_limit(CFG_MAX_SECONDS, 8'd0);
		write_limit(CFG_MAX_MINUTES, 8'd0);
		load_preset(8'd200, 8'd200);   // both above the limit
		press(BTN_C_LONG, 1'b0);
		press(BTN_A, 1'b0);             // above limit wraps to 0
		press(BTN_B, 1'b0);             // 0 -> limit
		press(BTN_A_LONG, 1'b0);
		press(BTN_C_LONG, 1'b0);
		press(BTN_B_LONG, 1'b0);        // 200 -> 190
		press(BTN_A, 1'b0);             // above limit wraps to 0
		drain_requests();
		write_limit(CFG_MAX_SECONDS, 8'd255);
		write_limit(CFG_MAX_MINUTES, 8'd255);
		press(BTN_B, 1'b0);             // 0 -> 255
		press(BTN_A_LONG, 1'b0);        // 255 + 10 overflows 8 bits: wraps to 0
		press(BTN_A_LONG, 1'b0);
		press(BTN_B_LONG, 1'b0);        // exactly 10: not above 10, wraps to limit
		press(BTN_C_LONG, 1'b0);        // save
		drain_requests();
	endtask

	task automatic test_display_overflow();
		load_preset(8'd255, 8'd255);    // over 255 whole minutes remain
		press(BTN_A, 1'b1);
		press(BTN_NONE, 1'b1);
		press(BTN_A, 1'b0);
		load_preset(8'd255, 8'd0);
		press(BTN_A, 1'b1);
		press(BTN_A, 1'b0);
		drain_requests();
	endtask

	// One-second countdown to the finish, with a long receiver hold-off early on
	// so the result register fills and the timer stops taking requests
	task automatic test_countdown_under_backpressure();
		load_preset(8'd0, 8'd1);
		press(BTN_A, 1'b1);
		for (int i = 0; i < 1002; i++) begin
			if (i == 20)
				hold_off_req = HOLD_OFF_CYCLES;
			press(BTN_NONE, 1'b1);
		end
		drain_requests();
	endtask

	// ---------------------------------------------------------------
	// Random sequences
	// ---------------------------------------------------------------
	task automatic edit_session();
		load_preset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		press(BTN_C_LONG, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 8))
			press(edit_button(), 1'($urandom_range(0, 1)));
		press(BTN_C_LONG, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 8))
			press(edit_button(), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 4) != 0)
			press(BTN_C_LONG, 1'($urandom_range(0, 1)));
		else
			load_preset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic run_session();
		case ($urandom_range(0, 2))
			0:       load_preset(8'd0, 8'd0);
			1:       load_preset(8'($urandom_range(0, 2)), 8'($urandom_range(0, 59)));
			default: load_preset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		endcase
		press(BTN_A, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(3, 30)) begin
			case ($urandom_range(0, 19))
				0:       press(BTN_A, 1'($urandom_range(0, 1)));
				1:       press(BTN_B, 1'($urandom_range(0, 1)));
				2:       press(BTN_C_LONG, 1'($urandom_range(0, 1)));
				3:       press(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
				default: press(BTN_NONE, $urandom_range(0, 4) != 0);
			endcase
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 10))
			send_request(make_request($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)),
				1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255))));
	endtask

	task automatic run_random(input int count);
		int first;
		first = requests_sent;
		while (requests_sent - first < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: edit_session();
				4, 5, 6, 7: run_session();
				default:    noise_burst();
			endcase
		end
	endtask

	// Each phase runs under its own pair of limits, written while idle
	task automatic test_random_phases();
		logic [7:0] secs_lim, mins_lim;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					secs_lim = MAX_SECONDS_RST;
					mins_lim = MAX_MINUTES_RST;
				end
				1: begin
					secs_lim = 8'd0;
					mins_lim = 8'd0;
				end
				2: begin
					secs_lim = 8'd255;
					mins_lim = 8'd255;
				end
				3: begin
					secs_lim = 8'($urandom_range(1, 20));
					mins_lim = 8'($urandom_range(1, 20));
				end
				default: begin
					secs_lim = 8'($urandom_range(0, 255));
					mins_lim = 8'($urandom_range(0, 255));
				end
			endcase
			write_limit(CFG_MAX_SECONDS, secs_lim);
			write_limit(CFG_MAX_MINUTES, mins_lim);
			run_random(RANDOM_PER_PHASE);
			drain_requests();
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence of tests
	// ---------------------------------------------------------------
	initial begin
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= 1'b0;
		req_ch.button       <= BTN_NONE;
		req_ch.tick         <= 1'b0;
		req_ch.load_minutes <= 8'd0;
		req_ch.load_seconds <= 8'd0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_MAX_SECONDS;
		cfg_data            <= 8'd0;
		reset_timer_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_after_reset();
		test_state_flow();
		test_edit_limits();
		test_display_overflow();
		test_countdown_under_backpressure();
		test_random_phases();
		drain_requests();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
